/* rtl/sgi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_pkg
// shared widths, payload types and the divider step for segment_intersection
// ----------------------------------------------------------------------------
package sgi_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DEN_BITS   = PROD_BITS + 1;
    localparam int REM_BITS   = DEN_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [DEN_BITS-1:0]   t_den;

    typedef struct packed {
        logic                  hit;
        t_coord                ax;
        t_coord                ay;
        logic                  neg_x;
        logic                  neg_y;
        logic [DEN_BITS-1:0]   a;
        logic [DEN_BITS-1:0]   d;
        logic [DIFF_BITS-1:0]  bx;
        logic [DIFF_BITS-1:0]  by;
        logic [REM_BITS-1:0]   rx;
        logic [REM_BITS-1:0]   ry;
        logic [DIFF_BITS-1:0]  qx;
        logic [DIFF_BITS-1:0]  qy;
    } t_div;

    typedef struct packed {
        logic [REM_BITS-1:0]  r;
        logic [DIFF_BITS-1:0] q;
    } t_rq;

    // one bit of floor(a*b/d)
    function automatic t_rq div_step(input logic [REM_BITS-1:0] r,
                                     input logic [DIFF_BITS-1:0] q,
                                     input logic [DEN_BITS-1:0] a,
                                     input logic [DEN_BITS-1:0] d,
                                     input logic b);
        t_rq                 res;
        logic [REM_BITS-1:0] dx;
        logic [REM_BITS-1:0] ax;
        dx    = {1'b0, d};
        ax    = {1'b0, a};
        res.r = {r[REM_BITS-2:0], 1'b0};
        res.q = {q[DIFF_BITS-2:0], 1'b0};
        if (res.r >= dx) begin
            res.r = res.r - dx;
            res.q = res.q + DIFF_BITS'(1);
        end
        if (b) begin
            res.r = res.r + ax;
            if (res.r >= dx) begin
                res.r = res.r - dx;
                res.q = res.q + DIFF_BITS'(1);
            end
        end
        return res;
    endfunction

endpackage

/* rtl/sgi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_front
// differences, cross products and the hit decision in three stages
// ----------------------------------------------------------------------------
module sgi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sgi_pkg::t_coord i_ax,
    input  sgi_pkg::t_coord i_ay,
    input  sgi_pkg::t_coord i_bx,
    input  sgi_pkg::t_coord i_by,
    input  sgi_pkg::t_coord i_cx,
    input  sgi_pkg::t_coord i_cy,
    input  sgi_pkg::t_coord i_ex,
    input  sgi_pkg::t_coord i_ey,
    output logic           o_valid,
    output sgi_pkg::t_div  o_div
);
    import sgi_pkg::*;

    logic   r_v1, r_v2, r_v3;
    t_coord r_ax1, r_ay1, r_ax2, r_ay2;
    t_diff  r_d1x, r_d1y, r_d2x, r_d2y, r_wx, r_wy;
    t_diff  r_d1x2, r_d1y2;
    t_prod  r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    t_div   r_div, n_div;
    t_den   den, sn, tn;
    logic   s_ok, t_ok;

    always_comb begin
        den = DEN_BITS'(r_p1) - DEN_BITS'(r_p2);
        sn  = DEN_BITS'(r_p3) - DEN_BITS'(r_p4);
        tn  = DEN_BITS'(r_p5) - DEN_BITS'(r_p6);
        if (den > 0) begin
            s_ok = (sn >= 0) && (sn <= den);
            t_ok = (tn >= 0) && (tn <= den);
        end else begin
            s_ok = (sn <= 0) && (sn >= den);
            t_ok = (tn <= 0) && (tn >= den);
        end
        n_div.hit   = (den != 0) && s_ok && t_ok;
        n_div.ax    = r_ax2;
        n_div.ay    = r_ay2;
        n_div.neg_x = r_d1x2 < 0;
        n_div.neg_y = r_d1y2 < 0;
        n_div.a     = (tn < 0) ? DEN_BITS'(-tn) : DEN_BITS'(tn);
        n_div.d     = (den < 0) ? DEN_BITS'(-den) : DEN_BITS'(den);
        n_div.bx    = (r_d1x2 < 0) ? DIFF_BITS'(-r_d1x2) : DIFF_BITS'(r_d1x2);
        n_div.by    = (r_d1y2 < 0) ? DIFF_BITS'(-r_d1y2) : DIFF_BITS'(r_d1y2);
        n_div.rx    = '0;
        n_div.ry    = '0;
        n_div.qx    = '0;
        n_div.qy    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax1  <= i_ax;
            r_ay1  <= i_ay;
            r_d1x  <= DIFF_BITS'(i_bx) - DIFF_BITS'(i_ax);
            r_d1y  <= DIFF_BITS'(i_by) - DIFF_BITS'(i_ay);
            r_d2x  <= DIFF_BITS'(i_ex) - DIFF_BITS'(i_cx);
            r_d2y  <= DIFF_BITS'(i_ey) - DIFF_BITS'(i_cy);
            r_wx   <= DIFF_BITS'(i_ax) - DIFF_BITS'(i_cx);
            r_wy   <= DIFF_BITS'(i_ay) - DIFF_BITS'(i_cy);
            r_ax2  <= r_ax1;
            r_ay2  <= r_ay1;
            r_d1x2 <= r_d1x;
            r_d1y2 <= r_d1y;
            r_p1   <= PROD_BITS'(r_d1x) * PROD_BITS'(r_d2y);
            r_p2   <= PROD_BITS'(r_d2x) * PROD_BITS'(r_d1y);
            r_p3   <= PROD_BITS'(r_d1x) * PROD_BITS'(r_wy);
            r_p4   <= PROD_BITS'(r_d1y) * PROD_BITS'(r_wx);
            r_p5   <= PROD_BITS'(r_d2x) * PROD_BITS'(r_wy);
            r_p6   <= PROD_BITS'(r_d2y) * PROD_BITS'(r_wx);
            r_div  <= n_div;
        end
    end

    assign o_valid = r_v3;
    assign o_div   = r_div;

endmodule

/* rtl/sgi_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgi_div_stage
// one quotient bit of the x and y offset division, registered
// ----------------------------------------------------------------------------
module sgi_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  sgi_pkg::t_div i_div,
    output logic          o_valid,
    output sgi_pkg::t_div o_div
);
    import sgi_pkg::*;

    logic r_valid;
    t_div r_div, n_div;
    t_rq  stx, sty;

    always_comb begin
        stx      = div_step(i_div.rx, i_div.qx, i_div.a, i_div.d, i_div.bx[DIFF_BITS-1]);
        sty      = div_step(i_div.ry, i_div.qy, i_div.a, i_div.d, i_div.by[DIFF_BITS-1]);
        n_div    = i_div;
        n_div.rx = stx.r;
        n_div.qx = stx.q;
        n_div.ry = sty.r;
        n_div.qy = sty.q;
        n_div.bx = {i_div.bx[DIFF_BITS-2:0], 1'b0};
        n_div.by = {i_div.by[DIFF_BITS-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule

/* rtl/segment_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_intersection
// parametric crossing test of two segments with crossing point, pipelined
// ----------------------------------------------------------------------------
// channel  direction  handshake                 payload
// in       input      i_in_valid / o_in_stall   i_first_*, i_second_*
// out      output     o_out_valid / i_out_stall o_hit, o_cross_x, o_cross_y
//
// three front stages, one divider stage per quotient bit (COORD_BITS + 1) and
// the output register; one pair per cycle while the output is not stalled
// reset clears all valid bits; a stall at the output while o_out_valid is high
// freezes the whole pipeline and is passed to the input
// ----------------------------------------------------------------------------
module segment_intersection (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sgi_pkg::t_coord i_first_start_x,
    input  sgi_pkg::t_coord i_first_start_y,
    input  sgi_pkg::t_coord i_first_end_x,
    input  sgi_pkg::t_coord i_first_end_y,
    input  sgi_pkg::t_coord i_second_start_x,
    input  sgi_pkg::t_coord i_second_start_y,
    input  sgi_pkg::t_coord i_second_end_x,
    input  sgi_pkg::t_coord i_second_end_y,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic            o_hit,
    output sgi_pkg::t_coord o_cross_x,
    output sgi_pkg::t_coord o_cross_y
);
    import sgi_pkg::*;

    localparam int NSTG = DIFF_BITS;

    logic               en;
    logic [NSTG:0]      v;
    t_div               dv [NSTG+1];
    logic               r_valid;
    logic               r_hit;
    t_coord             r_x, r_y;
    logic signed [DIFF_BITS:0] offx, offy, px, py;

    assign en         = !(r_valid && i_out_stall);
    assign o_in_stall = !en;

    sgi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_ax    (i_first_start_x),
        .i_ay    (i_first_start_y),
        .i_bx    (i_first_end_x),
        .i_by    (i_first_end_y),
        .i_cx    (i_second_start_x),
        .i_cy    (i_second_start_y),
        .i_ex    (i_second_end_x),
        .i_ey    (i_second_end_y),
        .o_valid (v[0]),
        .o_div   (dv[0])
    );

    for (genvar g = 0; g < NSTG; g++) begin : g_div
        sgi_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v[g]),
            .i_div   (dv[g]),
            .o_valid (v[g+1]),
            .o_div   (dv[g+1])
        );
    end

    always_comb begin
        offx = {1'b0, dv[NSTG].qx};
        offy = {1'b0, dv[NSTG].qy};
        if (dv[NSTG].neg_x) begin
            offx = -offx;
        end
        if (dv[NSTG].neg_y) begin
            offy = -offy;
        end
        px = (DIFF_BITS+1)'(dv[NSTG].ax) + offx;
        py = (DIFF_BITS+1)'(dv[NSTG].ay) + offy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= v[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= dv[NSTG].hit;
            r_x   <= dv[NSTG].hit ? px[COORD_BITS-1:0] : '0;
            r_y   <= dv[NSTG].hit ? py[COORD_BITS-1:0] : '0;
        end
    end

    assign o_out_valid = r_valid;
    assign o_hit       = r_hit;
    assign o_cross_x   = r_x;
    assign o_cross_y   = r_y;

endmodule

/* test/tb_segment_intersection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_intersection
// self-checking bench for the pipelined segment crossing test: directed
// corner pairs, then random crossing and non-crossing pairs with random idle
// and stall on both sides, checked in order against a built-in predictor
// ----------------------------------------------------------------------------
module tb_segment_intersection;
    import sgi_pkg::*;

    localparam int N_RANDOM   = 1700;
    localparam int LATENCY    = COORD_BITS + 5;
    localparam int WATCHDOG   = 5000;

    typedef struct {
        logic   hit;
        t_coord cx;
        t_coord cy;
    } t_crossing;

    class crossing_board;
        t_crossing pending[$];
        int        errors;
        int        hits;
        int        checked;

        function automatic longint scaled_offset(longint tn, longint den, longint dir);
            longint q;
            longint a;
            longint d;
            longint b;
            a = tn < 0 ? -tn : tn;
            d = den < 0 ? -den : den;
            b = dir < 0 ? -dir : dir;
            q = (a * b) / d;
            return dir < 0 ? -q : q;
        endfunction

        function automatic bit unit_range(longint num, longint den);
            if (den > 0) return num >= 0 && num <= den;
            return num <= 0 && num >= den;
        endfunction

        function void note_pair(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                                t_coord cx, t_coord cy, t_coord ex, t_coord ey);
            longint    d1x, d1y, d2x, d2y, wx, wy, den, sn, tn, px, py;
            t_crossing e;
            d1x = longint'(bx) - longint'(ax);
            d1y = longint'(by) - longint'(ay);
            d2x = longint'(ex) - longint'(cx);
            d2y = longint'(ey) - longint'(cy);
            wx  = longint'(ax) - longint'(cx);
            wy  = longint'(ay) - longint'(cy);
            den = d1x * d2y - d2x * d1y;
            sn  = d1x * wy - d1y * wx;
            tn  = d2x * wy - d2y * wx;
            e.hit = 1'b0;
            e.cx  = '0;
            e.cy  = '0;
            if (den != 0 && unit_range(sn, den) && unit_range(tn, den)) begin
                px = longint'(ax) + scaled_offset(tn, den, d1x);
                py = longint'(ay) + scaled_offset(tn, den, d1y);
                e.hit = 1'b1;
                e.cx  = t_coord'(px);
                e.cy  = t_coord'(py);
            end
            pending.insert(pending.size(), e);
        endfunction

        function void check_crossing(logic hit, t_coord cx, t_coord cy);
            t_crossing e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transfer hit=%0b x=%0d y=%0d", $time, hit, cx, cy);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (hit) hits++;
            if (hit !== e.hit) begin
                $display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
                errors++;
            end
            if (cx !== e.cx) begin
                $display("%0t: cross_x expected %0d actual %0d", $time, e.cx, cx);
                errors++;
            end
            if (cy !== e.cy) begin
                $display("%0t: cross_y expected %0d actual %0d", $time, e.cy, cy);
                errors++;
            end
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    t_coord f_sx = '0, f_sy = '0, f_ex = '0, f_ey = '0;
    t_coord s_sx = '0, s_sy = '0, s_ex = '0, s_ey = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;
    t_coord cross_x, cross_y;

    crossing_board board = new();
    bit     calm = 1'b0;
    bit     hold_long = 1'b0;
    int     idle_cycles = 0;
    bit     timed_out = 1'b0;

    always #1 clk = ~clk;

    segment_intersection DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_first_start_x(f_sx), .i_first_start_y(f_sy),
        .i_first_end_x(f_ex), .i_first_end_y(f_ey),
        .i_second_start_x(s_sx), .i_second_start_y(s_sy),
        .i_second_end_x(s_ex), .i_second_end_y(s_ey),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_hit(hit), .o_cross_x(cross_x), .o_cross_y(cross_y)
    );

    // receiver side: checks and an idle watchdog; the random stall follows below
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_crossing(hit, cross_x, cross_y);
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no transfer for %0d cycles", WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int n;
        @(posedge clk);
        while (1) begin
            if (hold_long) begin
                out_stall <= 1'b1;
                for (n = 0; n < 200; n++) @(posedge clk);
                hold_long = 1'b0;
            end
            out_stall <= (!calm && $urandom_range(99) < 32);
            @(posedge clk);
        end
    end

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($signed($urandom_range(64)) - 32);
            default: return t_coord'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    task automatic send_pair(t_coord ax, t_coord ay, t_coord bx, t_coord by,
                             t_coord cx, t_coord cy, t_coord ex, t_coord ey);
        while (!calm && $urandom_range(99) < 32) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        f_sx <= ax; f_sy <= ay; f_ex <= bx; f_ey <= by;
        s_sx <= cx; s_sy <= cy; s_ex <= ex; s_ey <= ey;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_pair(ax, ay, bx, by, cx, cy, ex, ey);
    endtask

    task automatic send_random(int mode);
        t_coord ax, ay, bx, by, mx, my, cx, cy;
        int     k;
        k  = (mode == 0) ? 0 : (($urandom_range(3) == 0) ? 0 : 2);
        ax = rnd_coord(k); ay = rnd_coord(k); bx = rnd_coord(k); by = rnd_coord(k);
        if ($urandom_range(99) < 60) begin
            // second segment through a point near the first one
            mx = t_coord'((longint'(ax) + longint'(bx)) / 2);
            my = t_coord'((longint'(ay) + longint'(by)) / 2);
            cx = mx + t_coord'($signed($urandom_range(2000)) - 1000);
            cy = my + t_coord'($signed($urandom_range(2000)) - 1000);
            send_pair(ax, ay, bx, by, cx, cy,
                      t_coord'(2 * longint'(mx) - cx), t_coord'(2 * longint'(my) - cy));
        end else begin
            send_pair(ax, ay, bx, by, rnd_coord(k), rnd_coord(k), rnd_coord(k), rnd_coord(k));
        end
    endtask

    task automatic drain;
        int n;
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        for (n = 0; n < LATENCY + 4; n++) @(posedge clk);
    endtask

    initial begin
        int i;
        t_coord mx, mn;
        mx = t_coord'(32767);
        mn = t_coord'(-32768);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain crossing, touching at an end point, parallel, collinear, degenerate
        send_pair(0, 0, 160, 160, 0, 160, 160, 0);
        send_pair(0, 0, 160, 0, 160, 0, 160, 160);
        send_pair(0, 0, 160, 0, 0, 16, 160, 16);
        send_pair(0, 0, 160, 0, 32, 0, 320, 0);
        send_pair(16, 16, 16, 16, 0, 0, 32, 32);
        send_pair(0, 0, 160, 160, 0, 320, 320, 0);
        send_pair(0, 0, 10, 0, 20, -5, 20, 5);
        send_pair(mn, mn, mx, mx, mn, mx, mx, mn);
        send_pair(mx, mn, mn, mx, mn, mn, mx, mx);
        send_pair(mn, 0, mx, 0, 0, mn, 0, mx);
        send_pair(mx, mx, mn, mn, mx, mn, mn, mx);
        send_pair(mn, mn, mn, mx, mx, mx, mn, 0);
        send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
        send_pair(0, 0, 3, 7, 0, 5, 5, 0);
        send_pair(-7, 3, 5, -11, -9, -9, 13, 2);
        send_pair(0, 0, 0, 0, 0, 0, 0, 0);
        send_pair(-1, -1, -1, -1, -1, -1, -1, -1);
        send_pair(mx, mx, mx, mx, mn, mn, mn, mn);

        // back pressure: long output hold while inputs keep coming
        calm = 1'b1;
        hold_long = 1'b1;
        for (i = 0; i < 60; i++) send_random(1);
        calm = 1'b0;
        drain();

        for (i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 400 && i < 700);
            send_random($urandom_range(2));
            if (i == 1000) drain();
        end
        calm = 1'b0;
        drain();

        $display("checked %0d crossing results, %0d of them hits", board.checked, board.hits);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
